FILE: src/caa_pkg.sv
// Package: shared types, mode codes and one-bit cell tables of the approximate adder.
`timescale 1ns / 1ps
`default_nettype none

package caa_pkg;

  localparam int DefaultWidth = 16;
  localparam int OperandW     = 16;
  localparam int ModeW        = 4;
  localparam int ApproxW      = 4;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 4;

  typedef enum logic [ModeW-1:0] {
    MODE_EXACT = 4'd0,
    MODE_AMA1  = 4'd1,
    MODE_AMA2  = 4'd2,
    MODE_AMA3  = 4'd3,
    MODE_AXA1  = 4'd4,
    MODE_AXA2  = 4'd5,
    MODE_AXA3  = 4'd6,
    MODE_LOA   = 4'd7,
    MODE_TRUNC = 4'd8,
    MODE_SEG   = 4'd9,
    MODE_ETA   = 4'd10
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE   = 1'b0,
    REG_APPROX = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [ApproxW-1:0] approx_bits;
  } caa_cfg_t;

  // cell kind 0 is the exact full adder; 1-3 AMA1-3, 4-6 AXA1-3
  localparam logic [7:0] CellSum [7] = '{8'h96, 8'h13, 8'h8A, 8'hCC, 8'hAA, 8'hC3, 8'h82};
  localparam logic [7:0] CellCarry [7] = '{8'hE8, 8'hEC, 8'hF0, 8'hF0, 8'hD4, 8'hE8, 8'hE8};

  // returns {carry, sum}
  function automatic logic [1:0] caa_cell(input logic [2:0] kind, input logic a,
                                          input logic b, input logic cin);
    logic [2:0] idx;
    logic [7:0] st;
    logic [7:0] ct;
    idx = {a, b, cin};
    st  = 8'h96;
    ct  = 8'hE8;
    if (kind < 3'd7) begin
      st = CellSum[kind];
      ct = CellCarry[kind];
    end
    return {ct[idx], st[idx]};
  endfunction

endpackage

`default_nettype wire

FILE: src/caa_if.sv
// Interfaces: operand, result and configuration channels of the approximate adder.
`timescale 1ns / 1ps
`default_nettype none

interface caa_in_if import caa_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [OperandW-1:0] operand_a;
  logic signed [OperandW-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface caa_out_if import caa_pkg::*; #(
  parameter int WIDTH = DefaultWidth
);
  logic                 valid;
  logic                 ready;
  logic signed [WIDTH:0] sum;

  modport source (output valid, output sum, input ready);
  modport sink   (input valid, input sum, output ready);
endinterface

interface caa_cfg_if import caa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/configurable_approximate_adder_top.sv
// Top level: configurable approximate adder with registered input and result stages.
//
// Usage:
//   in_i   - operand items (operand_a, operand_b, signed 16 bits; low WIDTH bits
//            used, sign-extended when WIDTH exceeds 16).
//   out_o  - result items, one per operand item, sum signed WIDTH+1 bits.
//   cfg_i  - register writes: index 0 mode, index 1 approx_bits; always ready.
//            Write only while no item is in flight.
// Path: an accepted item passes the operand register, then the result register.
// Throughput: one item per cycle unless out_o stalls; the adder row sits
//   between the operand register and the result register, one pass per item.
// Stall: when out_o.ready is low the result is held; one more item is taken
//   into the operand register, then in_i.ready drops until the result moves.
// Reset: both stages empty, mode 0 (exact) and approx_bits 0.
`timescale 1ns / 1ps
`default_nettype none

module configurable_approximate_adder_top import caa_pkg::*; #(
  parameter int WIDTH = DefaultWidth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  caa_in_if.sink    in_i,
  caa_out_if.source out_o,
  caa_cfg_if.sink   cfg_i
);

  caa_cfg_t            cfg;
  logic                s1_valid_q;
  logic                s1_valid_d;
  logic [OperandW-1:0] a_q;
  logic [OperandW-1:0] b_q;
  logic                out_valid_q;
  logic                out_valid_d;
  logic [WIDTH:0]      sum_q;
  logic [WIDTH:0]      sum_d;
  logic                out_free;
  logic                in_take;

  caa_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  caa_adder_core #(.WIDTH(WIDTH)) u_core (
    .cfg_i       (cfg),
    .operand_a_i (a_q),
    .operand_b_i (b_q),
    .sum_o       (sum_d)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_take    = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_take ? 1'b1 : (out_free ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_free ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_q <= in_i.operand_a;
      b_q <= in_i.operand_b;
    end
    if (out_free && s1_valid_q) begin
      sum_q <= sum_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.sum   = sum_q;

endmodule

`default_nettype wire

FILE: src/caa_cfg_regs.sv
// Configuration registers: adder mode and approximate bit count.
`timescale 1ns / 1ps
`default_nettype none

module caa_cfg_regs import caa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  caa_cfg_if.sink   cfg_i,
  output caa_cfg_t  cfg_o
);

  logic [ModeW-1:0]   mode_q;
  logic [ApproxW-1:0] approx_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_EXACT;
      approx_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MODE:   mode_q   <= ModeW'(cfg_i.data);
        REG_APPROX: approx_q <= ApproxW'(cfg_i.data);
        default: ;
      endcase
    end
  end

  assign cfg_o.mode        = mode_q;
  assign cfg_o.approx_bits = approx_q;

endmodule

`default_nettype wire

FILE: src/caa_adder_core.sv
// Adder core: row of selectable one-bit cells and signed result rebuild.
`timescale 1ns / 1ps
`default_nettype none

module caa_adder_core import caa_pkg::*; #(
  parameter int WIDTH = DefaultWidth
) (
  input  wire caa_cfg_t               cfg_i,
  input  wire logic [OperandW-1:0]    operand_a_i,
  input  wire logic [OperandW-1:0]    operand_b_i,
  output logic      [WIDTH:0]         sum_o
);

  localparam int IdxW   = $clog2(WIDTH + 1);
  localparam int CmpW   = (IdxW > ApproxW) ? IdxW : ApproxW;
  localparam int NumTab = 2 ** ApproxW;

  logic [WIDTH-1:0] a_w;
  logic [WIDTH-1:0] b_w;
  logic [WIDTH-1:0] s_bits;
  logic [WIDTH:0]   c_chain;
  logic [WIDTH-1:0] lo_mask;
  logic [WIDTH-1:0] lo_top;
  logic [WIDTH-1:0] seg_cut;
  logic [WIDTH-1:0] eta_cut;
  logic [WIDTH-1:0] seg_tab [NumTab];
  logic [WIDTH-1:0] eta_tab [NumTab];
  logic [CmpW-1:0]  ab_ext;
  logic             is_cellmode;
  logic             top_bit;
  logic             sgn_a;
  logic             sgn_b;

  if (WIDTH <= OperandW) begin : g_trunc
    assign a_w = operand_a_i[WIDTH-1:0];
    assign b_w = operand_b_i[WIDTH-1:0];
  end else begin : g_sext
    assign a_w = {{(WIDTH-OperandW){operand_a_i[OperandW-1]}}, operand_a_i};
    assign b_w = {{(WIDTH-OperandW){operand_b_i[OperandW-1]}}, operand_b_i};
  end

  // carry-cut masks per approx_bits setting, fixed at elaboration
  for (genvar k = 0; k < NumTab; k++) begin : g_tab
    localparam int SEG = (k < WIDTH) ? (WIDTH - k) : 1;
    localparam int BOT = WIDTH % SEG;
    for (genvar i = 0; i < WIDTH; i++) begin : g_bit
      assign seg_tab[k][i] = (i == 0) || ((i >= BOT) && (((i - BOT) % SEG) == 0));
      assign eta_tab[k][i] = ((i % SEG) == 0);
    end
  end

  assign ab_ext  = CmpW'(cfg_i.approx_bits);
  assign seg_cut = seg_tab[cfg_i.approx_bits];
  assign eta_cut = eta_tab[cfg_i.approx_bits];

  always_comb begin
    for (int i = 0; i < WIDTH; i++) begin
      lo_mask[i] = (ab_ext > CmpW'(i));
      lo_top[i]  = (ab_ext == CmpW'(i + 1));
    end
  end

  assign is_cellmode = (cfg_i.mode >= MODE_AMA1) && (cfg_i.mode <= MODE_AXA3);

  always_comb begin
    logic [1:0] cs;
    logic       cin;
    cs         = '0;
    cin        = 1'b0;
    c_chain[0] = 1'b0;
    for (int i = 0; i < WIDTH; i++) begin
      cin = c_chain[i];
      if (is_cellmode && lo_mask[i]) begin
        cs = caa_cell(cfg_i.mode[2:0], a_w[i], b_w[i], cin);
      end else if ((cfg_i.mode == MODE_LOA) && lo_mask[i]) begin
        cs = {lo_top[i] & a_w[i] & b_w[i], a_w[i] | b_w[i]};
      end else if ((cfg_i.mode == MODE_TRUNC) && lo_mask[i]) begin
        cs = 2'b00;
      end else if (cfg_i.mode == MODE_SEG) begin
        if (seg_cut[i]) begin
          cin = 1'b0;
        end
        cs = caa_cell(3'd0, a_w[i], b_w[i], cin);
      end else if (cfg_i.mode == MODE_ETA) begin
        cs = caa_cell(3'd0, a_w[i], b_w[i], cin);
        if (eta_cut[i]) begin
          cs[1] = a_w[i] & b_w[i];
        end
      end else begin
        cs = caa_cell(3'd0, a_w[i], b_w[i], cin);
      end
      s_bits[i]    = cs[0];
      c_chain[i+1] = cs[1];
    end
  end

  assign top_bit = s_bits[WIDTH-1];
  assign sgn_a   = a_w[WIDTH-1];
  assign sgn_b   = b_w[WIDTH-1];

  always_comb begin
    sum_o[WIDTH-2:0] = s_bits[WIDTH-2:0];
    if (!sgn_a && !sgn_b) begin
      sum_o[WIDTH:WIDTH-1] = {1'b0, top_bit};
    end else if (sgn_a && sgn_b && !top_bit) begin
      sum_o[WIDTH:WIDTH-1] = {c_chain[WIDTH], 1'b0};
    end else begin
      sum_o[WIDTH:WIDTH-1] = {top_bit, top_bit};
    end
  end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Testbench: approximate adder driven through every mode code with no, 15 and some approximate bits, checked per item.
`timescale 1ns / 1ps

module testbench;
  import caa_pkg::*;

  localparam int W         = DefaultWidth;
  localparam int PhaseLen  = 38;
  localparam int LongHold  = 48;
  localparam int Settle    = 4;
  localparam int IdleLimit = 1000;

  typedef struct packed {
    logic [OperandW-1:0] a;
    logic [OperandW-1:0] b;
  } operand_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  caa_in_if                 in_if ();
  caa_out_if #(.WIDTH(W))   out_if ();
  caa_cfg_if                cfg_if ();

  configurable_approximate_adder_top #(.WIDTH(W)) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #6 clk = ~clk;

  operand_pair_t        operand_q[$];
  logic signed [W:0]    sum_expect_q[$];
  logic [ModeW-1:0]     cur_mode;
  logic [ApproxW-1:0]   cur_approx;
  int unsigned          mismatches;
  int unsigned          holds_asked;
  int unsigned          holds_served;
  int unsigned          idle_cycles;

  // {carry, sum} of one adder cell
  function automatic logic [1:0] adder_cell(logic [ModeW-1:0] kind, logic x, logic y,
                                            logic ci);
    logic [7:0] st;
    logic [7:0] ct;
    logic [2:0] k;
    k = {x, y, ci};
    case (kind)
      MODE_AMA1: begin st = 8'h13; ct = 8'hEC; end
      MODE_AMA2: begin st = 8'h8A; ct = 8'hF0; end
      MODE_AMA3: begin st = 8'hCC; ct = 8'hF0; end
      MODE_AXA1: begin st = 8'hAA; ct = 8'hD4; end
      MODE_AXA2: begin st = 8'hC3; ct = 8'hE8; end
      MODE_AXA3: begin st = 8'h82; ct = 8'hE8; end
      default:   begin st = 8'h96; ct = 8'hE8; end
    endcase
    return {ct[k], st[k]};
  endfunction

  function automatic logic signed [W:0] approx_sum(logic [OperandW-1:0] opa,
                                                   logic [OperandW-1:0] opb,
                                                   logic [ModeW-1:0] md,
                                                   logic [ApproxW-1:0] nb);
    logic [W-1:0]     a;
    logic [W-1:0]     b;
    logic [W-1:0]     s;
    logic [ModeW-1:0] m;
    logic             carry;
    logic             cin;
    logic             si;
    logic             co;
    int               seg;
    int               bottom;
    longint           total;
    a = W'($signed(opa));
    b = W'($signed(opb));
    m = (md > MODE_ETA) ? MODE_EXACT : md;
    seg = (nb < W) ? W - nb : 1;
    bottom = W % seg;
    carry = 1'b0;
    for (int i = 0; i < W; i++) begin
      cin = carry;
      if (m >= MODE_AMA1 && m <= MODE_AXA3 && i < nb) begin
        {co, si} = adder_cell(m, a[i], b[i], cin);
      end else if (m == MODE_LOA && i < nb) begin
        si = a[i] | b[i];
        co = (i + 1 == nb) ? (a[i] & b[i]) : 1'b0;
      end else if (m == MODE_TRUNC && i < nb) begin
        si = 1'b0;
        co = 1'b0;
      end else if (m == MODE_SEG) begin
        if (i == 0 || (i >= bottom && (i - bottom) % seg == 0)) cin = 1'b0;
        {co, si} = adder_cell(MODE_EXACT, a[i], b[i], cin);
      end else if (m == MODE_ETA) begin
        {co, si} = adder_cell(MODE_EXACT, a[i], b[i], cin);
        if (i % seg == 0) co = a[i] & b[i];
      end else begin
        {co, si} = adder_cell(MODE_EXACT, a[i], b[i], cin);
      end
      s[i]  = si;
      carry = co;
    end
    // rebuild with the sign and carry rule
    total = longint'(s[W-2:0]);
    if (!a[W-1] && !b[W-1]) begin
      if (s[W-1]) total += longint'(1) << (W - 1);
    end else if (a[W-1] && b[W-1]) begin
      if (s[W-1]) total -= longint'(1) << (W - 1);
      else if (carry) total -= longint'(1) << W;
    end else if (s[W-1]) begin
      total -= longint'(1) << (W - 1);
    end
    return total[W:0];
  endfunction

  function automatic logic [OperandW-1:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return OperandW'($urandom());
    if (r < 8) return OperandW'(int'($urandom_range(0, 32)) - 16);
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // operand driver in bursts; also tracks the register settings
  always @(posedge clk or negedge rst_n) begin : drive_operands
    int unsigned   burst_left;
    int unsigned   gap_left;
    operand_pair_t nxt;
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.operand_a <= '0;
      in_if.operand_b <= '0;
      cur_mode        <= MODE_EXACT;
      cur_approx      <= '0;
      burst_left      = 0;
      gap_left        = 0;
    end else begin
      if (in_if.valid && in_if.ready)
        sum_expect_q.push_back(approx_sum(in_if.operand_a, in_if.operand_b,
                                          cur_mode, cur_approx));
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          REG_MODE:   cur_mode   <= cfg_if.data;
          REG_APPROX: cur_approx <= cfg_if.data;
          default: ;
        endcase
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left    = gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (operand_q.size() != 0) begin
          nxt = operand_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.operand_a <= nxt.a;
          in_if.operand_b <= nxt.b;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stall rate, redrawn periodically; long hold-off on request
  always @(posedge clk or negedge rst_n) begin : drive_ready
    int unsigned rx_cycle;
    int unsigned rx_pct;
    int unsigned hold_left;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_cycle     = 0;
      rx_pct       = 100;
      hold_left    = 0;
      holds_served <= 0;
    end else begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle % 256 == 0)
        rx_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 95);
      if (hold_left != 0) begin
        hold_left    = hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served <= holds_served + 1;
        hold_left    = LongHold;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(1, 100) <= rx_pct);
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : check_sums
    logic signed [W:0] exp_sum;
    if (!rst_n) begin
      mismatches <= 0;
    end else if (out_if.valid && out_if.ready) begin
      if (sum_expect_q.size() == 0) begin
        $error("unexpected result item: sum %0d", out_if.sum);
        mismatches <= mismatches + 1;
      end else begin
        exp_sum = sum_expect_q.pop_front();
        if (out_if.sum !== exp_sum) begin
          $error("sum mismatch: expected %0d, actual %0d", exp_sum, out_if.sum);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("configurable_approximate_adder_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (operand_q.size() != 0 || sum_expect_q.size() != 0 || in_if.valid === 1'b1)
      @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  initial begin
    operand_pair_t       p;
    logic [ApproxW-1:0]  nb;
    int                  ph;
    holds_asked  = 0;
    idle_cycles  = 0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MODE;
    cfg_if.data  = '0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // corners in the reset setting (exact adder)
    @(negedge clk);
    operand_q.push_back('{16'h0000, 16'h0000});
    operand_q.push_back('{16'h7FFF, 16'h7FFF});
    operand_q.push_back('{16'h8000, 16'h8000});
    operand_q.push_back('{16'h7FFF, 16'h8000});
    operand_q.push_back('{16'h8000, 16'h7FFF});
    operand_q.push_back('{16'hFFFF, 16'hFFFF});
    operand_q.push_back('{16'hFFFF, 16'h0001});
    operand_q.push_back('{16'h5555, 16'hAAAA});
    operand_q.push_back('{16'hAAAA, 16'hAAAA});
    operand_q.push_back('{16'h8000, 16'hFFFF});
    operand_q.push_back('{16'h4000, 16'h4000});
    operand_q.push_back('{16'hC000, 16'hC000});
    wait_drained();

    // every mode code, each with no, 15 (the largest) and some approximate bits
    ph = 0;
    for (int md = 0; md < 16; md++) begin
      for (int k = 0; k < 3; k++) begin
        nb = (k == 0) ? 4'd0 : (k == 1) ? 4'd15 : ApproxW'($urandom_range(1, 14));
        write_reg(REG_MODE, CfgDataW'(md));
        write_reg(REG_APPROX, nb);
        @(negedge clk);
        for (int n = 0; n < PhaseLen; n++) begin
          p.a = pick_operand();
          case ($urandom_range(0, 7))
            0:       p.b = ~p.a;
            1:       p.b = -p.a;
            2:       p.b = p.a;
            default: p.b = pick_operand();
          endcase
          operand_q.push_back(p);
        end
        if (ph % 10 == 3) holds_asked = holds_asked + 1;
        ph++;
        wait_drained();
      end
    end

    if (sum_expect_q.size() != 0)
      $error("%0d expected sum items never arrived", sum_expect_q.size());
    if (mismatches == 0 && sum_expect_q.size() == 0) begin
      $display("configurable_approximate_adder_top verification clean");
    end else begin
      $display("configurable_approximate_adder_top verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/caa_pkg.sv
src/caa_if.sv
src/caa_cfg_regs.sv
src/caa_adder_core.sv
src/configurable_approximate_adder_top.sv
verif/testbench.sv
